// File: rtl/scss_pkg.sv
// ----------------------------------------------------------------------------
// scss_pkg
// Shared types, codes and constants for the sensor compensation and
// seven-segment scan block.
// ----------------------------------------------------------------------------
package scss_pkg;

    // field and register widths
    localparam int RAW_W   = 20;
    localparam int CAL_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int VAL_W   = 10;
    localparam int DIGIT_W = 4;
    localparam int SLOT_W  = 4;
    localparam int SEG_W   = 8;

    // default scan length
    localparam int SCAN_SLOTS_DEF = 10;

    // calibration reset values
    localparam logic [CAL_W-1:0] CAL_T1_RST = 16'd27504;
    localparam logic [CAL_W-1:0] CAL_T2_RST = 16'd26435;
    localparam logic [CAL_W-1:0] CAL_T3_RST = 16'hFC18;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CAL_T1 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_T2 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_T3 = 2'd2;

    // command codes
    localparam logic CMD_MEASURE = 1'b0;
    localparam logic CMD_TICK    = 1'b1;

    // pressure rule
    localparam int PRES_OFFSET = 1638;
    localparam int PRES_GAIN   = 50;

    // clamp limit
    localparam int VAL_MAX = 999;

    // scan slot codes
    localparam logic [SLOT_W-1:0] SLOT_T_HUND = 4'd0;
    localparam logic [SLOT_W-1:0] SLOT_T_TENS = 4'd1;
    localparam logic [SLOT_W-1:0] SLOT_DOT    = 4'd2;
    localparam logic [SLOT_W-1:0] SLOT_T_ONES = 4'd3;
    localparam logic [SLOT_W-1:0] SLOT_C      = 4'd4;
    localparam logic [SLOT_W-1:0] SLOT_P_HUND = 4'd5;
    localparam logic [SLOT_W-1:0] SLOT_P_TENS = 4'd6;
    localparam logic [SLOT_W-1:0] SLOT_P_ONES = 4'd7;
    localparam logic [SLOT_W-1:0] SLOT_P      = 4'd8;

    // segment patterns
    localparam logic [SEG_W-1:0] SEG_DOT = 8'b1000_0000;
    localparam logic [SEG_W-1:0] SEG_C   = 8'b0011_1001;
    localparam logic [SEG_W-1:0] SEG_P   = 8'b0111_0011;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_SUM,
        S_DIG1,
        S_DIG2,
        S_TICK
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic mul1;
        logic mul2;
        logic sum;
        logic dig1;
        logic dig2;
        logic tick;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic out_free;
    } t_dp_status;

    // decimal digit to segment pattern
    function automatic logic [SEG_W-1:0] digit_seg(input logic [DIGIT_W-1:0] d);
        logic [SEG_W-1:0] s;
        case (d)
            4'd0:    s = 8'h3F;
            4'd1:    s = 8'h06;
            4'd2:    s = 8'h5B;
            4'd3:    s = 8'h4F;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'h6D;
            4'd6:    s = 8'h7D;
            4'd7:    s = 8'h07;
            4'd8:    s = 8'h7F;
            4'd9:    s = 8'h6F;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

endpackage

// File: rtl/scss_ctrl.sv
// ----------------------------------------------------------------------------
// scss_ctrl
// Sequencer: accepts items and steps the datapath through compensation,
// digit split and display tick.
// ----------------------------------------------------------------------------
module scss_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic                  i_command,
    output logic                  o_ready,
    input  scss_pkg::t_dp_status  i_status,
    output scss_pkg::t_dp_cmd     o_cmd
);

    scss_pkg::t_state r_state;
    scss_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= scss_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            scss_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load_in = 1'b1;
                    if (i_command == scss_pkg::CMD_TICK) begin
                        n_state = scss_pkg::S_TICK;
                    end else begin
                        n_state = scss_pkg::S_MUL1;
                    end
                end
            end
            scss_pkg::S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = scss_pkg::S_MUL2;
            end
            scss_pkg::S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = scss_pkg::S_SUM;
            end
            scss_pkg::S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = scss_pkg::S_DIG1;
            end
            scss_pkg::S_DIG1: begin
                o_cmd.dig1 = 1'b1;
                n_state    = scss_pkg::S_DIG2;
            end
            scss_pkg::S_DIG2: begin
                o_cmd.dig2 = 1'b1;
                n_state    = scss_pkg::S_IDLE;
            end
            scss_pkg::S_TICK: begin
                // wait until the output register can take the pattern
                if (i_status.out_free) begin
                    o_cmd.tick = 1'b1;
                    n_state    = scss_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = scss_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/scss_dp.sv
// ----------------------------------------------------------------------------
// scss_dp
// Datapath: calibration registers, compensation multipliers, clamp,
// decimal digit split, scan slot and output register.
// ----------------------------------------------------------------------------
module scss_dp #(
    parameter int SCAN_SLOTS = scss_pkg::SCAN_SLOTS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [scss_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [scss_pkg::CAL_W-1:0]          i_cfg_data,
    // input payload
    input  logic [scss_pkg::RAW_W-1:0]          i_raw_temp,
    input  logic [scss_pkg::RAW_W-1:0]          i_raw_pressure,
    // output channel
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [scss_pkg::SEG_W-1:0]          o_segment_code,
    output logic [scss_pkg::SLOT_W-1:0]         o_slot_shown,
    // sequencer link
    input  scss_pkg::t_dp_cmd                   i_cmd,
    output scss_pkg::t_dp_status                o_status
);

    localparam logic [scss_pkg::SLOT_W-1:0] SLOT_LAST = scss_pkg::SLOT_W'(SCAN_SLOTS - 1);

    // calibration registers
    logic        [15:0] r_cal_t1;
    logic signed [15:0] r_cal_t2;
    logic signed [15:0] r_cal_t3;

    // latched raw inputs and intermediate products
    logic        [19:0] r_adc;
    logic        [19:0] r_rp;
    logic signed [33:0] r_prod1;
    logic        [31:0] r_sq;
    logic signed [36:0] r_prod2;
    logic signed [25:0] r_pr;
    logic        [9:0]  r_temp;
    logic        [9:0]  r_pres;
    logic        [3:0]  r_hund_t;
    logic        [3:0]  r_hund_p;
    logic        [6:0]  r_rem_t;
    logic        [6:0]  r_rem_p;

    // displayed digits
    logic [3:0] r_t_hund, r_t_tens, r_t_ones;
    logic [3:0] r_p_hund, r_p_tens, r_p_ones;

    // scan and output
    logic [3:0] r_slot;
    logic       r_out_valid;
    logic [7:0] r_seg;
    logic [3:0] r_slot_shown;

    // first products
    logic signed [17:0] w_d1;
    logic signed [16:0] w_d2;
    logic signed [33:0] w_sq_full;
    logic signed [18:0] w_pd;

    // second products
    logic signed [20:0] w_sq_sh;

    // sum and clamp
    logic signed [24:0] w_fine;
    logic signed [15:0] w_tenths;
    logic        [9:0]  w_temp_clamp;
    logic        [9:0]  w_pres_clamp;

    // digit split
    logic [15:0] w_qt_prod, w_qp_prod;
    logic [3:0]  w_qt, w_qp;
    logic [9:0]  w_qt_sub, w_qp_sub;
    logic [14:0] w_tt_prod, w_tp_prod;
    logic [3:0]  w_tt, w_tp;
    logic [6:0]  w_tt_sub, w_tp_sub;

    // tick decode
    logic [7:0] w_code;
    logic       w_shown;

    assign w_d1      = $signed(18'(r_adc[19:3]) - {1'b0, r_cal_t1, 1'b0});
    assign w_d2      = $signed(17'(r_adc[19:4]) - {1'b0, r_cal_t1});
    assign w_sq_full = w_d2 * w_d2;
    assign w_pd      = $signed({1'b0, r_rp[19:2]}) - 19'sd1638;
    assign w_sq_sh   = $signed({1'b0, r_sq[31:12]});

    assign w_fine   = 25'(r_prod1 >>> 11) + 25'(r_prod2 >>> 14);
    assign w_tenths = 16'(w_fine >>> 9);

    // temperature: non-positive fine value reads as zero
    always_comb begin
        if (w_fine <= 25'sd0) begin
            w_temp_clamp = '0;
        end else if (w_tenths > 16'(scss_pkg::VAL_MAX)) begin
            w_temp_clamp = 10'(scss_pkg::VAL_MAX);
        end else begin
            w_temp_clamp = w_tenths[9:0];
        end
    end

    // pressure clamp
    always_comb begin
        if (r_pr < 26'sd0) begin
            w_pres_clamp = '0;
        end else if (r_pr > 26'(scss_pkg::VAL_MAX)) begin
            w_pres_clamp = 10'(scss_pkg::VAL_MAX);
        end else begin
            w_pres_clamp = r_pr[9:0];
        end
    end

    // hundreds by reciprocal: v/100 = (v*41)>>12 for v below 1000
    assign w_qt_prod = 16'(r_temp) * 16'd41;
    assign w_qp_prod = 16'(r_pres) * 16'd41;
    assign w_qt      = w_qt_prod[15:12];
    assign w_qp      = w_qp_prod[15:12];
    assign w_qt_sub  = 10'(w_qt) * 10'd100;
    assign w_qp_sub  = 10'(w_qp) * 10'd100;

    // tens by reciprocal: r/10 = (r*205)>>11 for r below 100
    assign w_tt_prod = 15'(r_rem_t) * 15'd205;
    assign w_tp_prod = 15'(r_rem_p) * 15'd205;
    assign w_tt      = w_tt_prod[14:11];
    assign w_tp      = w_tp_prod[14:11];
    assign w_tt_sub  = 7'(w_tt) * 7'd10;
    assign w_tp_sub  = 7'(w_tp) * 7'd10;

    // slot decode
    always_comb begin
        w_shown = 1'b1;
        w_code  = '0;
        case (r_slot)
            scss_pkg::SLOT_T_HUND: w_code = scss_pkg::digit_seg(r_t_hund);
            scss_pkg::SLOT_T_TENS: w_code = scss_pkg::digit_seg(r_t_tens);
            scss_pkg::SLOT_DOT:    w_code = scss_pkg::SEG_DOT;
            scss_pkg::SLOT_T_ONES: w_code = scss_pkg::digit_seg(r_t_ones);
            scss_pkg::SLOT_C:      w_code = scss_pkg::SEG_C;
            scss_pkg::SLOT_P_HUND: w_code = scss_pkg::digit_seg(r_p_hund);
            scss_pkg::SLOT_P_TENS: w_code = scss_pkg::digit_seg(r_p_tens);
            scss_pkg::SLOT_P_ONES: w_code = scss_pkg::digit_seg(r_p_ones);
            scss_pkg::SLOT_P:      w_code = scss_pkg::SEG_P;
            default:               w_shown = 1'b0;
        endcase
    end

    // calibration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_t1 <= scss_pkg::CAL_T1_RST;
            r_cal_t2 <= $signed(scss_pkg::CAL_T2_RST);
            r_cal_t3 <= $signed(scss_pkg::CAL_T3_RST);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                scss_pkg::REG_CAL_T1: r_cal_t1 <= i_cfg_data;
                scss_pkg::REG_CAL_T2: r_cal_t2 <= $signed(i_cfg_data);
                scss_pkg::REG_CAL_T3: r_cal_t3 <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // compensation pipeline payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_adc <= i_raw_temp;
            r_rp  <= i_raw_pressure;
        end
        if (i_cmd.mul1) begin
            r_prod1 <= w_d1 * r_cal_t2;
            r_sq    <= w_sq_full[31:0];
        end
        if (i_cmd.mul2) begin
            r_prod2 <= w_sq_sh * r_cal_t3;
            r_pr    <= w_pd * 26'sd50;
        end
        if (i_cmd.sum) begin
            r_temp <= w_temp_clamp;
            r_pres <= w_pres_clamp;
        end
        if (i_cmd.dig1) begin
            r_hund_t <= w_qt;
            r_hund_p <= w_qp;
            r_rem_t  <= 7'(r_temp - w_qt_sub);
            r_rem_p  <= 7'(r_pres - w_qp_sub);
        end
    end

    // displayed digits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_hund <= '0;
            r_t_tens <= '0;
            r_t_ones <= '0;
            r_p_hund <= '0;
            r_p_tens <= '0;
            r_p_ones <= '0;
        end else if (i_cmd.dig2) begin
            r_t_hund <= r_hund_t;
            r_t_tens <= w_tt;
            r_t_ones <= 4'(r_rem_t - w_tt_sub);
            r_p_hund <= r_hund_p;
            r_p_tens <= w_tp;
            r_p_ones <= 4'(r_rem_p - w_tp_sub);
        end
    end

    // scan slot and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.tick) begin
                if (r_slot == SLOT_LAST) begin
                    r_slot <= '0;
                end else begin
                    r_slot <= r_slot + 4'd1;
                end
            end
            // a new pattern fills the register, a transfer empties it
            if (i_cmd.tick && w_shown) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tick && w_shown) begin
            r_seg        <= w_code;
            r_slot_shown <= r_slot;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_segment_code    = r_seg;
    assign o_slot_shown      = r_slot_shown;
    assign o_status.out_free = !r_out_valid || i_ready;

endmodule

// File: rtl/sensor_compensate_segment_scan.sv
// ----------------------------------------------------------------------------
// sensor_compensate_segment_scan
// Temperature and pressure compensation with a seven-segment display scan.
// ----------------------------------------------------------------------------
// Measure item: two multiply steps, sum and clamp, then two reciprocal
//   digit-split steps before the next ready; no result.
// Tick item: passes the tick state, then the pattern enters the output
//   register, later only while a previous pattern waits; a blank slot loads none.
// Reset (synchronous, active low): calibration words to defaults, digits and
//   scan slot to zero, output empty. No clearing pass.
module sensor_compensate_segment_scan #(
    parameter int SCAN_SLOTS = scss_pkg::SCAN_SLOTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [scss_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [scss_pkg::CAL_W-1:0]      i_cfg_data,
    // input channel
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_command,
    input  logic [scss_pkg::RAW_W-1:0]      i_raw_temp,
    input  logic [scss_pkg::RAW_W-1:0]      i_raw_pressure,
    // output channel
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [scss_pkg::SEG_W-1:0]      o_segment_code,
    output logic [scss_pkg::SLOT_W-1:0]     o_slot_shown
);

    scss_pkg::t_dp_cmd    w_cmd;
    scss_pkg::t_dp_status w_status;

    // sequencer
    scss_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_command (i_command),
        .o_ready   (o_ready),
        .i_status  (w_status),
        .o_cmd     (w_cmd)
    );

    // datapath
    scss_dp #(
        .SCAN_SLOTS (SCAN_SLOTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_raw_temp     (i_raw_temp),
        .i_raw_pressure (i_raw_pressure),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_segment_code (o_segment_code),
        .o_slot_shown   (o_slot_shown),
        .i_cmd          (w_cmd),
        .o_status       (w_status)
    );

endmodule

// File: test/tb_sensor_compensate_segment_scan.sv
// ----------------------------------------------------------------------------
// tb_sensor_compensate_segment_scan
// Self-checking bench for the sensor compensation and seven-segment scan.
// A queue of measure and tick items feeds a valid/ready driver, and a monitor
// predicts each shown segment pattern from its own copy of the calibration
// words, the clamped readings and the scan position. It compares every
// output transfer with the oldest prediction. Calibration is changed between
// phases while the block is idle, the extreme words among the settings.
// ----------------------------------------------------------------------------
module tb_sensor_compensate_segment_scan;

    // run control
    localparam int CYCLE_LIMIT = 200000;
    localparam int LATENCY_PAD = 12;
    localparam int LONG_HOLD   = 250;
    localparam int MAX_REPORTS = 10;
    localparam int SCAN_SLOTS  = scss_pkg::SCAN_SLOTS_DEF;

    // index with no register behind it
    localparam logic [scss_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // segment patterns of the digits 9 down to 0
    localparam logic [10*scss_pkg::SEG_W-1:0] DIGIT_SEGS = {
        8'h6F, 8'h7F, 8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
    };

    typedef struct packed {
        logic                       command;
        logic [scss_pkg::RAW_W-1:0] raw_temp;
        logic [scss_pkg::RAW_W-1:0] raw_pressure;
        logic [3:0]                 gap;
    } t_sensor_item;

    typedef struct packed {
        logic [scss_pkg::SEG_W-1:0]  code;
        logic [scss_pkg::SLOT_W-1:0] slot;
    } t_segment;

    // clock and block ports
    logic                           i_clk          = 1'b0;
    logic                           i_rst_n        = 1'b0;
    logic                           i_cfg_we       = 1'b0;
    logic [scss_pkg::CFG_IDX_W-1:0] i_cfg_index    = '0;
    logic [scss_pkg::CAL_W-1:0]     i_cfg_data     = '0;
    logic                           i_valid        = 1'b0;
    logic                           o_ready;
    logic                           i_command      = scss_pkg::CMD_MEASURE;
    logic [scss_pkg::RAW_W-1:0]     i_raw_temp     = '0;
    logic [scss_pkg::RAW_W-1:0]     i_raw_pressure = '0;
    logic                           o_valid;
    logic                           i_ready        = 1'b0;
    logic [scss_pkg::SEG_W-1:0]     o_segment_code;
    logic [scss_pkg::SLOT_W-1:0]    o_slot_shown;

    // stimulus and expected patterns
    t_sensor_item sensor_items[$];
    t_segment     expected_segments[$];

    int items_sent     = 0;
    int items_taken    = 0;
    int segments_taken = 0;
    int mismatches     = 0;
    int hold_requests  = 0;

    // predictor copy of the block
    logic [scss_pkg::CAL_W-1:0]  t1_word    = scss_pkg::CAL_T1_RST;
    logic [scss_pkg::CAL_W-1:0]  t2_word    = scss_pkg::CAL_T2_RST;
    logic [scss_pkg::CAL_W-1:0]  t3_word    = scss_pkg::CAL_T3_RST;
    logic [scss_pkg::VAL_W-1:0]  shown_temp = '0;
    logic [scss_pkg::VAL_W-1:0]  shown_pres = '0;
    logic [scss_pkg::SLOT_W-1:0] scan_pos   = '0;

    // driver and receiver bookkeeping
    t_sensor_item tx_item;
    int           tx_wait       = 0;
    int           rx_stall      = 0;
    int           rx_hold       = 0;
    int           rx_hold_seen  = 0;
    int           rx_taken_seen = 0;
    logic         rx_no_stall   = 1'b0;

    sensor_compensate_segment_scan dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_command      (i_command),
        .i_raw_temp     (i_raw_temp),
        .i_raw_pressure (i_raw_pressure),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_segment_code (o_segment_code),
        .o_slot_shown   (o_slot_shown)
    );

    always #10 i_clk = ~i_clk;

    // wait cycles for one item, none in a burst
    function automatic logic [3:0] draw_wait(input logic no_idle);
        logic [31:0] r;
        r = no_idle ? 32'd0 : $urandom_range(9, 0);
        return r[3:0];
    endfunction

    function automatic logic [scss_pkg::RAW_W-1:0] draw_raw(input int unsigned lo,
                                                            input int unsigned hi);
        logic [31:0] r;
        r = $urandom_range(hi, lo);
        return r[scss_pkg::RAW_W-1:0];
    endfunction

    function automatic logic [scss_pkg::SEG_W-1:0] digit_pattern(input int d);
        return DIGIT_SEGS[d*scss_pkg::SEG_W +: scss_pkg::SEG_W];
    endfunction

    // saturate a reading to the three display digits
    function automatic logic [scss_pkg::VAL_W-1:0] clamp_reading(input longint v);
        if (v < 0)
            return '0;
        if (v > scss_pkg::VAL_MAX)
            return scss_pkg::VAL_W'(scss_pkg::VAL_MAX);
        return v[scss_pkg::VAL_W-1:0];
    endfunction

    // integer temperature compensation and linear pressure rule
    function automatic void compensate_measure(input logic [scss_pkg::RAW_W-1:0] rt,
                                               input logic [scss_pkg::RAW_W-1:0] rp);
        longint adc, t1, t2, t3, d1, d2, v1, v2, sq, fine, tenths, pr;
        adc = longint'(rt);
        t1  = longint'(t1_word);
        t2  = $signed(t2_word);
        t3  = $signed(t3_word);
        d1  = (adc >>> 3) - 2 * t1;
        v1  = (d1 * t2) >>> 11;
        d2  = (adc >>> 4) - t1;
        sq  = (d2 * d2) >>> 12;
        v2  = (sq * t3) >>> 14;
        fine   = v1 + v2;
        tenths = (fine > 0) ? fine / 512 : 0;
        pr     = ((longint'(rp) >>> 2) - scss_pkg::PRES_OFFSET) * scss_pkg::PRES_GAIN;
        shown_temp = clamp_reading(tenths);
        shown_pres = clamp_reading(pr);
    endfunction

    // pattern of the current slot, then step the scan
    function automatic void scan_segment();
        t_segment seg;
        logic     lit;
        lit      = 1'b1;
        seg.code = '0;
        seg.slot = scan_pos;
        case (scan_pos)
            scss_pkg::SLOT_T_HUND: seg.code = digit_pattern((int'(shown_temp) / 100) % 10);
            scss_pkg::SLOT_T_TENS: seg.code = digit_pattern((int'(shown_temp) / 10) % 10);
            scss_pkg::SLOT_DOT:    seg.code = scss_pkg::SEG_DOT;
            scss_pkg::SLOT_T_ONES: seg.code = digit_pattern(int'(shown_temp) % 10);
            scss_pkg::SLOT_C:      seg.code = scss_pkg::SEG_C;
            scss_pkg::SLOT_P_HUND: seg.code = digit_pattern((int'(shown_pres) / 100) % 10);
            scss_pkg::SLOT_P_TENS: seg.code = digit_pattern((int'(shown_pres) / 10) % 10);
            scss_pkg::SLOT_P_ONES: seg.code = digit_pattern(int'(shown_pres) % 10);
            scss_pkg::SLOT_P:      seg.code = scss_pkg::SEG_P;
            default:               lit = 1'b0;
        endcase
        if (int'(scan_pos) == SCAN_SLOTS - 1)
            scan_pos = '0;
        else
            scan_pos = scan_pos + 4'd1;
        if (lit)
            expected_segments.push_back(seg);
    endfunction

    task automatic add_item(input logic cmd, input logic [scss_pkg::RAW_W-1:0] rt,
                            input logic [scss_pkg::RAW_W-1:0] rp, input logic [3:0] gap);
        t_sensor_item it;
        it.command      = cmd;
        it.raw_temp     = rt;
        it.raw_pressure = rp;
        it.gap          = gap;
        sensor_items.push_back(it);
    endtask

    // raw words around the interesting ranges, with full-range noise
    task automatic add_random_item(input logic cmd, input logic no_idle);
        logic [scss_pkg::RAW_W-1:0] rt, rp;
        case ($urandom_range(3, 0))
            0:       rt = draw_raw(380000, 720000);
            1:       rt = ($urandom_range(1, 0) == 0) ? '0 : '1;
            default: rt = draw_raw(0, (1 << scss_pkg::RAW_W) - 1);
        endcase
        case ($urandom_range(3, 0))
            0:       rp = draw_raw(6540, 6640);
            1:       rp = draw_raw(6400, 6800);
            2:       rp = ($urandom_range(1, 0) == 0) ? '0 : '1;
            default: rp = draw_raw(0, (1 << scss_pkg::RAW_W) - 1);
        endcase
        add_item(cmd, rt, rp, draw_wait(no_idle));
    endtask

    // mostly a measurement followed by a run of ticks, some loose items
    task automatic queue_random_scan(input int count);
        int   added, run;
        logic no_idle;
        added = 0;
        while (added < count) begin
            no_idle = ($urandom_range(3, 0) == 0);
            if ($urandom_range(9, 0) < 8) begin
                add_random_item(scss_pkg::CMD_MEASURE, no_idle);
                run = $urandom_range(12, 1);
                repeat (run) add_random_item(scss_pkg::CMD_TICK, no_idle);
                added += run + 1;
            end else begin
                run = $urandom_range(4, 1);
                repeat (run) add_random_item($urandom_range(1, 0) == 1, no_idle);
                added += run;
            end
        end
    endtask

    task automatic write_reg(input logic [scss_pkg::CFG_IDX_W-1:0] idx,
                             input logic [scss_pkg::CAL_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            scss_pkg::REG_CAL_T1: t1_word = data;
            scss_pkg::REG_CAL_T2: t2_word = data;
            scss_pkg::REG_CAL_T3: t3_word = data;
            default:    ;
        endcase
    endtask

    task automatic set_calibration(input logic [scss_pkg::CAL_W-1:0] t1,
                                   input logic [scss_pkg::CAL_W-1:0] t2,
                                   input logic [scss_pkg::CAL_W-1:0] t3);
        write_reg(scss_pkg::REG_CAL_T1, t1);
        write_reg(scss_pkg::REG_CAL_T2, t2);
        write_reg(scss_pkg::REG_CAL_T3, t3);
    endtask

    // sender stops until every pattern is back, then the block settles
    task automatic wait_drained();
        while (sensor_items.size() != 0 || items_sent != items_taken ||
               expected_segments.size() != 0)
            @(negedge i_clk);
        repeat (LATENCY_PAD) @(negedge i_clk);
    endtask

    // input driver: one item at a time, after its drawn gap
    always @(negedge i_clk) begin
        if (i_rst_n && items_sent == items_taken) begin
            if (sensor_items.size() != 0 && tx_wait >= int'(sensor_items[0].gap)) begin
                tx_item = sensor_items.pop_front();
                i_valid        <= 1'b1;
                i_command      <= tx_item.command;
                i_raw_temp     <= tx_item.raw_temp;
                i_raw_pressure <= tx_item.raw_pressure;
                items_sent++;
                tx_wait = 0;
            end else begin
                i_valid <= 1'b0;
                if (sensor_items.size() != 0)
                    tx_wait++;
            end
        end
    end

    // output receiver: drawn stall per pattern, long hold on request
    always @(negedge i_clk) begin
        if (rx_hold_seen != hold_requests) begin
            rx_hold_seen = hold_requests;
            rx_hold      = LONG_HOLD;
        end
        if (rx_taken_seen != segments_taken) begin
            rx_taken_seen = segments_taken;
            if ($urandom_range(29, 0) == 0)
                rx_no_stall = ~rx_no_stall;
            rx_stall = int'(draw_wait(rx_no_stall));
        end
        if (rx_hold > 0) begin
            rx_hold--;
            i_ready <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // monitor: predict on input transfers, check output transfers
    always @(posedge i_clk) begin : monitor
        t_segment want;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                items_taken <= items_taken + 1;
                if (i_command == scss_pkg::CMD_MEASURE)
                    compensate_measure(i_raw_temp, i_raw_pressure);
                else
                    scan_segment();
            end
            if (o_valid && i_ready) begin
                segments_taken <= segments_taken + 1;
                if (expected_segments.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected pattern %h in slot %0d",
                                 o_segment_code, o_slot_shown);
                end else begin
                    want = expected_segments.pop_front();
                    if (o_segment_code !== want.code || o_slot_shown !== want.slot) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("pattern mismatch: expected %h slot %0d, got %h slot %0d",
                                     want.code, want.slot, o_segment_code, o_slot_shown);
                    end
                end
            end
        end
    end

    // stimulus phases
    initial begin : stimulus
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // readings below zero, a full scan with the blank slot
        add_item(scss_pkg::CMD_MEASURE, 20'h00000, 20'h00000, 4'd0);
        repeat (5) add_item(scss_pkg::CMD_TICK, 20'hFFFFF, 20'hFFFFF, 4'd0);
        repeat (5) add_item(scss_pkg::CMD_TICK, 20'h00000, 20'h00000, draw_wait(1'b0));
        // readings above the display range
        add_item(scss_pkg::CMD_MEASURE, 20'hFFFFF, 20'hFFFFF, 4'd1);
        repeat (5) add_item(scss_pkg::CMD_TICK, 20'h5A5A5, 20'hA5A5A, draw_wait(1'b0));
        // mid-range readings, pressure slots and the wrap
        add_item(scss_pkg::CMD_MEASURE, 20'd519888, 20'd6595, 4'd0);
        repeat (5) add_item(scss_pkg::CMD_TICK, 20'hA5A5A, 20'h5A5A5, draw_wait(1'b0));
        wait_drained();

        // write to the missing index is ignored
        write_reg(REG_UNUSED, 16'h1234);
        queue_random_scan(100);
        @(negedge i_clk);
        hold_requests <= hold_requests + 1;
        wait_drained();

        set_calibration(16'h0000, 16'h7FFF, 16'h8000);
        queue_random_scan(70);
        wait_drained();

        set_calibration(16'hFFFF, 16'h8000, 16'h7FFF);
        queue_random_scan(70);
        wait_drained();

        set_calibration(scss_pkg::CAL_W'($urandom_range(35000, 20000)),
                        scss_pkg::CAL_W'($urandom_range(30000, 20000)),
                        scss_pkg::CAL_W'(-$urandom_range(2000, 0)));
        queue_random_scan(90);
        wait_drained();

        set_calibration(scss_pkg::CAL_W'($urandom()), scss_pkg::CAL_W'($urandom()),
                        scss_pkg::CAL_W'($urandom()));
        queue_random_scan(80);
        @(negedge i_clk);
        hold_requests <= hold_requests + 1;
        wait_drained();

        set_calibration(scss_pkg::CAL_T1_RST, scss_pkg::CAL_T2_RST, scss_pkg::CAL_T3_RST);
        queue_random_scan(80);
        wait_drained();

        if (expected_segments.size() != 0) begin
            mismatches++;
            $display("%0d patterns never arrived", expected_segments.size());
        end
        if (mismatches == 0)
            $display("sensor_compensate_segment_scan verification clean");
        else
            $display("sensor_compensate_segment_scan verification failed");
        $finish;
    end

    // cycle limit, far above the slowest run with every stall drawn
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("sensor_compensate_segment_scan verification failed");
        $finish;
    end

endmodule
